FILE: rtl/core/rsq_pkg.sv
// shared types and constants for the retransmit slot queue
// used by the controller, the datapath and the top level
`default_nettype none

package rsq_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    localparam int STAMP_W = 16;
    localparam int SEQ_W   = 16;

    localparam logic [STAMP_W-1:0] STAMP_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_ALLOC = 3'd0,
        KIND_PUSH  = 3'd1,
        KIND_POP   = 3'd2,
        KIND_PEEK  = 3'd3,
        KIND_ACK   = 3'd4,
        KIND_FREE  = 3'd5,
        KIND_CLEAR = 3'd6
    } t_kind;

    // commands from the controller to the datapath
    typedef struct packed {
        logic exec;       // operation on the accepted item that needs no scan
        logic scan_init;  // latch key and reset the scan registers
        logic alloc_step; // examine one slot for allocation
        logic ack_step;   // examine one queue entry for acknowledge
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic alloc_free;
        logic alloc_last;
        logic ack_hit;
        logic ack_last;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/core/rsq_ctrl.sv
// controller state machine for the retransmit slot queue
// depends on rsq_pkg for command and status types
`default_nettype none

module rsq_ctrl import rsq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [2:0]        i_kind,
    input  wire t_stat             i_stat,
    output t_cmd                   o_cmd,
    output logic                   o_busy
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ALLOC = 3'b010,
        ST_ACK   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (t_kind'(i_kind) == KIND_ALLOC) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_ALLOC;
                    end else if (t_kind'(i_kind) == KIND_ACK && !i_stat.empty) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_ACK;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            ST_ALLOC: begin
                o_cmd.alloc_step = 1'b1;
                if (i_stat.alloc_free || i_stat.alloc_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ACK: begin
                o_cmd.ack_step = 1'b1;
                if (i_stat.ack_hit || i_stat.ack_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/rsq_dp.sv
// datapath of the retransmit slot queue: slot pool, order ring, scan and result registers
// depends on rsq_pkg for command and status types
`default_nettype none

module rsq_dp import rsq_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [2:0]         i_kind,
    input  wire logic [SLOT_W-1:0]  i_slot,
    input  wire logic [SEQ_W-1:0]   i_seq_number,
    output t_stat                   o_stat,
    output logic                    o_done,
    output logic [SLOT_W-1:0]       o_slot_out,
    output logic                    o_valid_res,
    output logic                    o_evicted,
    output logic                    o_overflow,
    output logic [CNT_W-1:0]        o_entries
);

    function automatic logic [SLOT_W-1:0] ptr_next(input logic [SLOT_W-1:0] p);
        return (p == SLOT_W'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [SLOTS-1:0]   r_busy;
    logic [STAMP_W-1:0] r_stamp [SLOTS];
    logic [SEQ_W-1:0]   r_seq   [SLOTS];
    logic [SLOT_W-1:0]  r_ring  [SLOTS];
    logic [SLOT_W-1:0]  r_head;
    logic [SLOT_W-1:0]  r_tail;
    logic [CNT_W-1:0]   r_count;
    logic [STAMP_W-1:0] r_stamp_ctr;

    // scan registers
    logic [SLOT_W-1:0]  r_idx;
    logic [CNT_W-1:0]   r_left;
    logic [STAMP_W-1:0] r_limit;
    logic [SLOT_W-1:0]  r_victim;
    logic [SEQ_W-1:0]   r_key;

    // result registers
    logic               r_done;
    logic [SLOT_W-1:0]  r_slot_out;
    logic               r_valid;
    logic               r_evicted;
    logic               r_overflow;

    logic [SLOT_W-1:0]  ring_head;
    logic [STAMP_W-1:0] stamp_cur;
    logic               take_victim;
    logic               full;

    assign ring_head = r_ring[r_head];
    assign stamp_cur = r_stamp[r_idx];
    assign full      = (r_count == CNT_W'(SLOTS));
    assign take_victim = ({1'b0, stamp_cur} + (STAMP_W+1)'(SLOTS) <= {1'b0, r_limit})
                      || (stamp_cur == STAMP_MAX);

    assign o_stat.empty      = (r_count == '0);
    assign o_stat.alloc_free = !r_busy[r_idx];
    assign o_stat.alloc_last = (r_idx == SLOT_W'(SLOTS - 1));
    assign o_stat.ack_hit    = (r_seq[ring_head] == r_key);
    assign o_stat.ack_last   = (r_left == CNT_W'(1));

    // control state: busy bits, pointers, count, stamp counter, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_stamp_ctr <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.exec
                   || (i_cmd.alloc_step && (o_stat.alloc_free || o_stat.alloc_last))
                   || (i_cmd.ack_step && (o_stat.ack_hit || o_stat.ack_last));
            if (i_cmd.exec) begin
                unique case (t_kind'(i_kind))
                    KIND_PUSH: begin
                        if (!full) begin
                            r_tail  <= ptr_next(r_tail);
                            r_count <= r_count + 1'b1;
                        end
                    end
                    KIND_POP: begin
                        if (!o_stat.empty) begin
                            r_head  <= ptr_next(r_head);
                            r_count <= r_count - 1'b1;
                        end
                    end
                    KIND_FREE: begin
                        r_busy[i_slot] <= 1'b0;
                    end
                    KIND_CLEAR: begin
                        r_head  <= '0;
                        r_tail  <= '0;
                        r_count <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.alloc_step && o_stat.alloc_free) begin
                r_busy[r_idx] <= 1'b1;
                r_stamp_ctr   <= r_stamp_ctr + 1'b1;
            end
            if (i_cmd.ack_step) begin
                r_head <= ptr_next(r_head);
                if (o_stat.ack_hit) begin
                    r_busy[ring_head] <= 1'b0;
                    r_count           <= r_count - 1'b1;
                end else begin
                    r_tail <= ptr_next(r_tail);
                end
            end
        end
    end

    // stores, scan registers and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_evicted <= 1'b0;
            unique case (t_kind'(i_kind)) inside
                KIND_PUSH: begin
                    r_overflow <= full;
                    r_valid    <= !full;
                    r_slot_out <= full ? '0 : i_slot;
                    if (!full) begin
                        r_seq[i_slot]  <= i_seq_number;
                        r_ring[r_tail] <= i_slot;
                    end
                end
                KIND_POP, KIND_PEEK: begin
                    r_overflow <= 1'b0;
                    r_valid    <= !o_stat.empty;
                    r_slot_out <= o_stat.empty ? '0 : ring_head;
                end
                KIND_FREE: begin
                    r_overflow <= 1'b0;
                    r_valid    <= 1'b1;
                    r_slot_out <= i_slot;
                end
                default: begin
                    r_overflow <= 1'b0;
                    r_valid    <= 1'b0;
                    r_slot_out <= '0;
                end
            endcase
        end
        if (i_cmd.scan_init) begin
            r_idx    <= '0;
            r_left   <= r_count;
            r_limit  <= STAMP_MAX;
            r_victim <= '0;
            r_key    <= i_seq_number;
        end
        if (i_cmd.alloc_step) begin
            r_idx <= r_idx + 1'b1;
            if (o_stat.alloc_free) begin
                r_stamp[r_idx] <= r_stamp_ctr;
                r_slot_out     <= r_idx;
                r_valid        <= 1'b1;
                r_evicted      <= 1'b0;
                r_overflow     <= 1'b0;
            end else begin
                if (take_victim) begin
                    r_limit  <= stamp_cur;
                    r_victim <= r_idx;
                end
                if (o_stat.alloc_last) begin
                    r_slot_out <= take_victim ? r_idx : r_victim;
                    r_valid    <= 1'b1;
                    r_evicted  <= 1'b1;
                    r_overflow <= 1'b0;
                end
            end
        end
        if (i_cmd.ack_step) begin
            r_left <= r_left - 1'b1;
            r_evicted  <= 1'b0;
            r_overflow <= 1'b0;
            if (o_stat.ack_hit) begin
                r_slot_out <= ring_head;
                r_valid    <= 1'b1;
            end else begin
                // rotate the non-matching entry to the tail
                r_ring[r_tail] <= ring_head;
                r_slot_out     <= '0;
                r_valid        <= 1'b0;
            end
        end
    end

    assign o_done      = r_done;
    assign o_slot_out  = r_slot_out;
    assign o_valid_res = r_valid;
    assign o_evicted   = r_evicted;
    assign o_overflow  = r_overflow;
    assign o_entries   = r_count;

endmodule

`default_nettype wire

FILE: rtl/core/retransmit_slot_queue_core.sv
// top level of the retransmit slot queue
// instantiates rsq_ctrl and rsq_dp, depends on rsq_pkg
//
// usage: drive i_kind, i_slot and i_seq_number with i_start high; the item is
// taken at a clock edge where i_start is high and o_busy is low. every item
// gives exactly one result, shown for one cycle with o_done high on o_slot_out,
// o_valid_res, o_evicted, o_overflow and o_entries. the receiver cannot stall,
// so the result must be captured in that cycle.
// push, pop, peek, free, clear, unused kinds and acknowledge on an empty queue show
// their result in the cycle after the transfer and never raise o_busy, so one
// such item can follow every cycle.
// allocate walks the slots one per cycle from slot 0 and stops at the lowest free
// slot, or at the last slot when all are busy and a victim is evicted.
// acknowledge walks the queue from the head one entry per cycle and stops at the
// match or at the last entry.
// o_busy is high while a walk runs; the next item may be taken in the cycle
// the result is shown.
// reset (synchronous, active low) frees all slots, empties the queue and
// clears the stamp counter; no clearing pass is needed.
`default_nettype none

module retransmit_slot_queue_core import rsq_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [2:0]         i_kind,
    input  wire logic [SLOT_W-1:0]  i_slot,
    input  wire logic [SEQ_W-1:0]   i_seq_number,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [SLOT_W-1:0]       o_slot_out,
    output logic                    o_valid_res,
    output logic                    o_evicted,
    output logic                    o_overflow,
    output logic [CNT_W-1:0]        o_entries
);

    t_cmd  cmd;
    t_stat stat;

    rsq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    rsq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_kind       (i_kind),
        .i_slot       (i_slot),
        .i_seq_number (i_seq_number),
        .o_stat       (stat),
        .o_done       (o_done),
        .o_slot_out   (o_slot_out),
        .o_valid_res  (o_valid_res),
        .o_evicted    (o_evicted),
        .o_overflow   (o_overflow),
        .o_entries    (o_entries)
    );

endmodule

`default_nettype wire

FILE: test/tb.sv
// self-checking testbench for retransmit_slot_queue_core
// a scoreboard class predicts every result; depends on rsq_pkg and the core rtl
`default_nettype none

module tb import rsq_pkg::*; ();

    localparam logic [2:0]         KIND_UNUSED  = 3'd7;
    localparam int                 RANDOM_ITEMS = 1450;
    localparam int                 CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              valid;
        logic              evicted;
        logic              overflow;
        logic [CNT_W-1:0]  entries;
    } t_outcome;

    class slot_queue_scoreboard;
        bit                 busy [SLOTS];
        logic [STAMP_W-1:0] stamp [SLOTS];
        logic [SEQ_W-1:0]   seq_of [SLOTS];
        logic [SLOT_W-1:0]  ring [SLOTS];
        logic [SLOT_W-1:0]  head;
        logic [SLOT_W-1:0]  tail;
        int                 count;
        logic [STAMP_W-1:0] stamp_ctr;
        t_outcome           awaited [$];
        int                 errors;

        function new();
            foreach (busy[i]) busy[i] = 1'b0;
            head      = '0;
            tail      = '0;
            count     = 0;
            stamp_ctr = '0;
            errors    = 0;
        endfunction

        function void append(logic [SLOT_W-1:0] s);
            ring[tail] = s;
            tail       = tail + 1'b1;
            count++;
        endfunction

        function logic [SLOT_W-1:0] take();
            logic [SLOT_W-1:0] s;
            s    = ring[head];
            head = head + 1'b1;
            count--;
            return s;
        endfunction

        // work out the result of one accepted transfer and queue it
        function void note_item(logic [2:0] kind, logic [SLOT_W-1:0] slot,
                                logic [SEQ_W-1:0] key);
            t_outcome          res;
            int                limit;
            int                n;
            logic [SLOT_W-1:0] s;
            bit                found;
            res   = '0;
            found = 1'b0;
            case (kind) inside
                KIND_ALLOC: begin
                    limit       = 65535;
                    res.valid   = 1'b1;
                    res.evicted = 1'b1;
                    for (int i = 0; i < SLOTS && !found; i++) begin
                        if (!busy[i]) begin
                            busy[i]     = 1'b1;
                            stamp[i]    = stamp_ctr;
                            stamp_ctr   = stamp_ctr + 1'b1;
                            res.slot    = SLOT_W'(i);
                            res.evicted = 1'b0;
                            found       = 1'b1;
                        end else if (int'(stamp[i]) + SLOTS <= limit ||
                                     stamp[i] == STAMP_MAX) begin
                            limit    = int'(stamp[i]);
                            res.slot = SLOT_W'(i);
                        end
                    end
                end
                KIND_PUSH: begin
                    if (count >= SLOTS) begin
                        res.overflow = 1'b1;
                    end else begin
                        seq_of[slot] = key;
                        append(slot);
                        res.slot  = slot;
                        res.valid = 1'b1;
                    end
                end
                KIND_POP, KIND_PEEK: begin
                    if (count != 0) begin
                        if (kind == KIND_POP) begin
                            res.slot = take();
                        end else begin
                            res.slot = ring[head];
                        end
                        res.valid = 1'b1;
                    end
                end
                KIND_ACK: begin
                    // entries in front of the match rotate to the tail
                    n = count;
                    for (int i = 0; i < n && !found; i++) begin
                        s = take();
                        if (seq_of[s] !== key) begin
                            append(s);
                        end else begin
                            busy[s]   = 1'b0;
                            res.slot  = s;
                            res.valid = 1'b1;
                            found     = 1'b1;
                        end
                    end
                end
                KIND_FREE: begin
                    busy[slot] = 1'b0;
                    res.slot   = slot;
                    res.valid  = 1'b1;
                end
                KIND_CLEAR: begin
                    head  = '0;
                    tail  = '0;
                    count = 0;
                end
                default: begin
                end
            endcase
            res.entries = CNT_W'(count);
            awaited.push_back(res);
        endfunction

        function void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_outcome got);
            t_outcome exp;
            if (awaited.size() == 0) begin
                errors++;
                $error("result with no transfer outstanding: slot_out %0d", got.slot);
                return;
            end
            exp = awaited.pop_front();
            check_field("slot_out", 8'(exp.slot), 8'(got.slot));
            check_field("valid_res", 8'(exp.valid), 8'(got.valid));
            check_field("evicted", 8'(exp.evicted), 8'(got.evicted));
            check_field("overflow", 8'(exp.overflow), 8'(got.overflow));
            check_field("entries", 8'(exp.entries), 8'(got.entries));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic [2:0]        i_kind;
    logic [SLOT_W-1:0] i_slot;
    logic [SEQ_W-1:0]  i_seq_number;
    logic              o_busy;
    logic              o_done;
    logic [SLOT_W-1:0] o_slot_out;
    logic              o_valid_res;
    logic              o_evicted;
    logic              o_overflow;
    logic [CNT_W-1:0]  o_entries;

    slot_queue_scoreboard sb;
    int                   cycles;
    bit                   idle_on;
    bit                   drain;

    retransmit_slot_queue_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_kind       (i_kind),
        .i_slot       (i_slot),
        .i_seq_number (i_seq_number),
        .o_busy       (o_busy),
        .o_done       (o_done),
        .o_slot_out   (o_slot_out),
        .o_valid_res  (o_valid_res),
        .o_evicted    (o_evicted),
        .o_overflow   (o_overflow),
        .o_entries    (o_entries)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result({o_slot_out, o_valid_res, o_evicted, o_overflow, o_entries});
        end
    end

    function int draw_gap();
        return idle_on ? int'($urandom_range(0, 14)) : 0;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task send_item(input logic [2:0] kind, input logic [SLOT_W-1:0] slot,
                   input logic [SEQ_W-1:0] key, input int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start      <= 1'b1;
        i_kind       <= kind;
        i_slot       <= slot;
        i_seq_number <= key;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(kind, slot, key);
        @(negedge i_clk);
    endtask

    task random_item();
        int                pick;
        int                k;
        logic [2:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  key;
        pick = $urandom_range(0, 99);
        if (pick < 18)      kind = KIND_ALLOC;
        else if (pick < 46) kind = KIND_PUSH;
        else if (pick < 54) kind = KIND_POP;
        else if (pick < 60) kind = KIND_PEEK;
        else if (pick < 82) kind = KIND_ACK;
        else if (pick < 93) kind = KIND_FREE;
        else if (pick < 96) kind = KIND_CLEAR;
        else                kind = KIND_UNUSED;
        if (drain && kind == KIND_PUSH && $urandom_range(0, 1) == 1) begin
            kind = KIND_ACK;
        end
        slot = SLOT_W'($urandom_range(0, SLOTS - 1));
        // small keys make repeated sequence numbers likely
        key = ($urandom_range(0, 1) == 1) ? SEQ_W'($urandom_range(0, 15)) : SEQ_W'($urandom);
        if (kind == KIND_ACK && sb.count > 0 && $urandom_range(0, 3) != 0) begin
            k   = $urandom_range(0, sb.count - 1);
            key = sb.seq_of[sb.ring[SLOT_W'(sb.head + k)]];
        end
        send_item(kind, slot, key, draw_gap());
    endtask

    task random_stretch(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
                drain   = ($urandom_range(0, 2) == 0);
            end
            random_item();
        end
    endtask

    initial begin
        sb           = new();
        idle_on      = 1'b1;
        drain        = 1'b0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_kind       = KIND_ALLOC;
        i_slot       = '0;
        i_seq_number = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue, unused kind, then a small queue with a repeated slot
        send_item(KIND_POP, 4'd0, 16'h0000, draw_gap());
        send_item(KIND_PEEK, 4'd15, 16'hFFFF, draw_gap());
        send_item(KIND_ACK, 4'd0, 16'hFFFF, draw_gap());
        send_item(KIND_UNUSED, 4'd15, 16'hFFFF, draw_gap());
        send_item(KIND_CLEAR, 4'd0, 16'h0000, draw_gap());
        send_item(KIND_ALLOC, 4'd0, 16'h0000, draw_gap());
        send_item(KIND_ALLOC, 4'd15, 16'hFFFF, draw_gap());
        send_item(KIND_PUSH, 4'd0, 16'hFFFF, draw_gap());
        send_item(KIND_PUSH, 4'd15, 16'h0000, draw_gap());
        send_item(KIND_PUSH, 4'd0, 16'h1234, draw_gap());
        send_item(KIND_PEEK, 4'd0, 16'h0000, draw_gap());
        send_item(KIND_ACK, 4'd0, 16'hFFFF, draw_gap());
        send_item(KIND_ACK, 4'd0, 16'h0000, draw_gap());
        send_item(KIND_POP, 4'd0, 16'h0000, draw_gap());
        send_item(KIND_FREE, 4'd0, 16'h0000, draw_gap());
        send_item(KIND_FREE, 4'd15, 16'h0000, draw_gap());
        send_item(KIND_PUSH, 4'd1, 16'hA5A5, draw_gap());
        send_item(KIND_PUSH, 4'd14, 16'h5A5A, draw_gap());
        send_item(KIND_CLEAR, 4'd0, 16'h0000, draw_gap());
        send_item(KIND_POP, 4'd0, 16'h0000, draw_gap());
        send_item(KIND_ALLOC, 4'd0, 16'h0000, draw_gap());

        random_stretch(RANDOM_ITEMS);

        i_start <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
